### rtl/gtl_pkg.sv
package gtl_pkg;

  // input operation codes
  localparam logic [1:0] OP_GLYPH = 2'd0;
  localparam logic [1:0] OP_KERN  = 2'd1;
  localparam logic [1:0] OP_CHAR  = 2'd2;

  // queue depths between the parts
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 8;

  // scale register after reset: 1.0 in unsigned q8.8
  localparam logic [15:0] SCALE_RESET = 16'h0100;

  // item kinds after classification
  typedef enum logic [1:0] {
    KIND_GLYPH,
    KIND_KERN,
    KIND_CHAR
  } kind_e;

  // classified item between front and back
  typedef struct packed {
    kind_e             kind;
    logic              in_range;
    logic [7:0]        code;
    logic [7:0]        second_code;
    logic [11:0]       atlas_x;
    logic [11:0]       atlas_y;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic [7:0]        advance;
    logic signed [7:0] kern_amount;
    logic              start_of_string;
  } item_t;

  // one glyph table entry
  typedef struct packed {
    logic [11:0]       atlas_x;
    logic [11:0]       atlas_y;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic [7:0]        advance;
  } glyph_t;

  // one emitted quad
  typedef struct packed {
    logic signed [23:0] quad_x_min;
    logic signed [23:0] quad_x_max;
    logic signed [23:0] quad_y_min;
    logic signed [23:0] quad_y_max;
    logic [11:0]        tex_left;
    logic [11:0]        tex_top;
    logic [12:0]        tex_right;
    logic [12:0]        tex_bottom;
    logic [7:0]         glyph_char;
  } result_t;

endpackage

### rtl/glyph_text_layout.sv
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------------
// input    | push, full         | op, code, second_code, glyph and kern data
// result   | empty, pop         | quad edges (q16.8), texel rect, glyph_char
// config   | cfg_we_i           | cfg_wdata_i -> scale (unsigned q8.8)
//
// one item per cycle while the result queue has room; a character passes the item
// queue, glyph ram read, pen and quad registers on its way to the result queue
// the pen add with saturation is the feedback loop that sets the rate
// reset clears the present marks, the kerning fill and the pen at once
// the back stops issuing when queued plus in-flight results fill the result
// queue; full rises only when the item queue behind it is full
module glyph_text_layout
  import gtl_pkg::*;
#(
  parameter int unsigned GLYPH_DEPTH = 256,
  parameter int unsigned KERN_DEPTH  = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         op_i,
  input  logic [7:0]         code_i,
  input  logic [7:0]         second_code_i,
  input  logic [11:0]        atlas_x_i,
  input  logic [11:0]        atlas_y_i,
  input  logic [7:0]         glyph_width_i,
  input  logic [7:0]         glyph_height_i,
  input  logic signed [7:0]  offset_x_i,
  input  logic signed [7:0]  offset_y_i,
  input  logic [7:0]         advance_i,
  input  logic signed [7:0]  kern_amount_i,
  input  logic               start_of_string_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] quad_x_min_o,
  output logic signed [23:0] quad_x_max_o,
  output logic signed [23:0] quad_y_min_o,
  output logic signed [23:0] quad_y_max_o,
  output logic [11:0]        tex_left_o,
  output logic [11:0]        tex_top_o,
  output logic [12:0]        tex_right_o,
  output logic [12:0]        tex_bottom_o,
  output logic [7:0]         glyph_char_o
);

  localparam int unsigned IW = $bits(item_t);
  localparam int unsigned RW = $bits(result_t);

  logic                          front_push;
  item_t                         front_item;
  logic [IW-1:0]                 mid_data;
  logic                          mid_empty;
  logic                          mid_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  logic                          res_push;
  result_t                       res_in;
  logic [RW-1:0]                 res_data;
  result_t                       res_out;
  logic                          res_full;
  logic [$clog2(RES_DEPTH+1)-1:0] res_count;

  // decode and filter
  gtl_front #(
    .GLYPH_DEPTH (GLYPH_DEPTH)
  ) u_front (
    .push_i            (push),
    .full_i            (full),
    .op_i              (op_i),
    .code_i            (code_i),
    .second_code_i     (second_code_i),
    .atlas_x_i         (atlas_x_i),
    .atlas_y_i         (atlas_y_i),
    .glyph_width_i     (glyph_width_i),
    .glyph_height_i    (glyph_height_i),
    .offset_x_i        (offset_x_i),
    .offset_y_i        (offset_y_i),
    .advance_i         (advance_i),
    .kern_amount_i     (kern_amount_i),
    .start_of_string_i (start_of_string_i),
    .q_push_o          (front_push),
    .item_o            (front_item)
  );

  // item queue between front and back
  gtl_queue #(
    .WIDTH (IW),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_item),
    .pop_i   (mid_pop),
    .data_o  (mid_data),
    .full_o  (full),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  // table updates, pen and quad generation
  gtl_back #(
    .GLYPH_DEPTH (GLYPH_DEPTH),
    .KERN_DEPTH  (KERN_DEPTH),
    .OUT_DEPTH   (RES_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (!mid_empty),
    .item_i       (item_t'(mid_data)),
    .item_pop_o   (mid_pop),
    .res_count_i  (res_count),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  // result queue toward the consumer
  gtl_queue #(
    .WIDTH (RW),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_data),
    .full_o  (res_full),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign res_out      = result_t'(res_data);
  assign quad_x_min_o = res_out.quad_x_min;
  assign quad_x_max_o = res_out.quad_x_max;
  assign quad_y_min_o = res_out.quad_y_min;
  assign quad_y_max_o = res_out.quad_y_max;
  assign tex_left_o   = res_out.tex_left;
  assign tex_top_o    = res_out.tex_top;
  assign tex_right_o  = res_out.tex_right;
  assign tex_bottom_o = res_out.tex_bottom;
  assign glyph_char_o = res_out.glyph_char;

  // items are never taken from an empty queue and results never overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> (mid_count != '0))
    else $error("item transfer from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result queue overrun");

endmodule

### rtl/gtl_ram.sv
module gtl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/gtl_queue.sv
module gtl_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [CW-1:0]    count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // producers must respect full
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue push while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

### rtl/gtl_front.sv
module gtl_front
  import gtl_pkg::*;
#(
  parameter int unsigned GLYPH_DEPTH = 256
) (
  input  logic              push_i,
  input  logic              full_i,
  input  logic [1:0]        op_i,
  input  logic [7:0]        code_i,
  input  logic [7:0]        second_code_i,
  input  logic [11:0]       atlas_x_i,
  input  logic [11:0]       atlas_y_i,
  input  logic [7:0]        glyph_width_i,
  input  logic [7:0]        glyph_height_i,
  input  logic signed [7:0] offset_x_i,
  input  logic signed [7:0] offset_y_i,
  input  logic [7:0]        advance_i,
  input  logic signed [7:0] kern_amount_i,
  input  logic              start_of_string_i,
  output logic              q_push_o,
  output item_t             item_o
);

  logic  in_range;
  logic  keep;
  kind_e kind;

  // code fits the glyph table
  assign in_range = ({24'b0, code_i} < GLYPH_DEPTH);

  // classify: unused op and out-of-range glyph loads are dropped here
  always_comb begin
    keep = 1'b0;
    kind = KIND_CHAR;
    case (op_i)
      OP_GLYPH: begin
        kind = KIND_GLYPH;
        keep = in_range;
      end
      OP_KERN: begin
        kind = KIND_KERN;
        keep = 1'b1;
      end
      OP_CHAR: begin
        kind = KIND_CHAR;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push_o = push_i && !full_i && keep;

  always_comb begin
    item_o.kind            = kind;
    item_o.in_range        = in_range;
    item_o.code            = code_i;
    item_o.second_code     = second_code_i;
    item_o.atlas_x         = atlas_x_i;
    item_o.atlas_y         = atlas_y_i;
    item_o.glyph_width     = glyph_width_i;
    item_o.glyph_height    = glyph_height_i;
    item_o.offset_x        = offset_x_i;
    item_o.offset_y        = offset_y_i;
    item_o.advance         = advance_i;
    item_o.kern_amount     = kern_amount_i;
    item_o.start_of_string = start_of_string_i;
  end

endmodule

### rtl/gtl_back.sv
module gtl_back
  import gtl_pkg::*;
#(
  parameter int unsigned GLYPH_DEPTH = 256,
  parameter int unsigned KERN_DEPTH  = 64,
  parameter int unsigned OUT_DEPTH   = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [15:0]                      cfg_wdata_i,
  input  logic                             item_valid_i,
  input  item_t                            item_i,
  output logic                             item_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]   res_count_i,
  output logic                             res_push_o,
  output result_t                          res_o
);

  localparam int unsigned GAW = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
  localparam int unsigned KFW = $clog2(KERN_DEPTH + 1);
  localparam int unsigned KIW = (KERN_DEPTH > 1) ? $clog2(KERN_DEPTH) : 1;
  localparam int unsigned RCW = $clog2(OUT_DEPTH + 1);
  localparam int unsigned GW  = $bits(glyph_t);

  function automatic logic [23:0] sat24(input logic signed [27:0] v);
    logic [23:0] r;
    if (v > 28'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -28'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [15:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  // ---------------- stage 0: issue ----------------
  logic                  s1_emit_q, s2_emit_q, s3_emit_q;
  logic [RCW:0]          load_sum;
  logic                  issue;
  logic [GAW-1:0]        gaddr;
  logic                  glyph_wr;
  glyph_t                glyph_wdata;
  logic [GW-1:0]         glyph_rdata;
  logic [GLYPH_DEPTH-1:0] present_q;
  logic                  present0;
  logic [7:0]            prev_char_q;
  logic                  prev_present_q;
  logic                  has_step0;
  logic                  is_char0;

  // results queued plus results still in the pipe
  assign load_sum = {1'b0, res_count_i} + (RCW+1)'(s1_emit_q) + (RCW+1)'(s2_emit_q)
                  + (RCW+1)'(s3_emit_q);
  assign issue      = item_valid_i && (load_sum < (RCW+1)'(OUT_DEPTH));
  assign item_pop_o = issue;

  assign gaddr    = item_i.code[GAW-1:0];
  assign is_char0 = (item_i.kind == KIND_CHAR);
  assign glyph_wr = issue && (item_i.kind == KIND_GLYPH);
  assign present0 = is_char0 && item_i.in_range && present_q[gaddr];
  assign has_step0 = !item_i.start_of_string && prev_present_q;

  always_comb begin
    glyph_wdata.atlas_x      = item_i.atlas_x;
    glyph_wdata.atlas_y      = item_i.atlas_y;
    glyph_wdata.glyph_width  = item_i.glyph_width;
    glyph_wdata.glyph_height = item_i.glyph_height;
    glyph_wdata.offset_x     = item_i.offset_x;
    glyph_wdata.offset_y     = item_i.offset_y;
    glyph_wdata.advance      = item_i.advance;
  end

  gtl_ram #(
    .WIDTH (GW),
    .DEPTH (GLYPH_DEPTH)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_wr),
    .waddr_i (gaddr),
    .wdata_i (glyph_wdata),
    .raddr_i (gaddr),
    .rdata_o (glyph_rdata)
  );

  // present marks and previous character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q      <= '0;
      prev_char_q    <= '0;
      prev_present_q <= 1'b0;
    end else begin
      if (glyph_wr) begin
        present_q[gaddr] <= 1'b1;
      end
      if (issue && is_char0) begin
        prev_char_q    <= item_i.code;
        prev_present_q <= present0;
      end
    end
  end

  // ---------------- kerning pairs ----------------
  logic [KFW-1:0]        fill_q;
  logic [15:0]           key_q [KERN_DEPTH];
  logic [7:0]            amt_q [KERN_DEPTH];
  logic [KERN_DEPTH-1:0] live;
  logic [KERN_DEPTH-1:0] look_match;
  logic [KERN_DEPTH-1:0] dup_match;
  logic                  kern_wr;
  logic [15:0]           look_key, load_key;

  assign look_key = {prev_char_q, item_i.code};
  assign load_key = {item_i.code, item_i.second_code};
  assign kern_wr  = issue && (item_i.kind == KIND_KERN) && (fill_q < KFW'(KERN_DEPTH));

  // parallel compare against every filled pair
  always_comb begin
    for (int i = 0; i < KERN_DEPTH; i++) begin
      live[i]       = (KFW'(i) < fill_q);
      look_match[i] = live[i] && (key_q[i] == look_key);
      dup_match[i]  = live[i] && (key_q[i] == load_key);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (kern_wr) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  // a reloaded pair also refreshes older copies so matches always agree
  always_ff @(posedge clk_i) begin
    if (kern_wr) begin
      for (int i = 0; i < KERN_DEPTH; i++) begin
        if (dup_match[i]) begin
          amt_q[i] <= item_i.kern_amount;
        end
      end
      key_q[fill_q[KIW-1:0]] <= load_key;
      amt_q[fill_q[KIW-1:0]] <= item_i.kern_amount;
    end
  end

  // ---------------- stage 1: products ----------------
  logic                  s1_valid_q;
  item_t                 s1_item_q;
  logic                  s1_step_q;
  logic [KERN_DEPTH-1:0] s1_match_q;
  logic [7:0]            adv_q;
  logic [7:0]            lc1_q;
  glyph_t                g1;
  logic [KERN_DEPTH-1:0] amt_col [8];
  logic [7:0]            kern1;
  logic signed [9:0]     adv_sum;
  logic signed [16:0]    scale_s;
  logic signed [26:0]    step1;
  logic signed [24:0]    oxs1, oys1;
  logic [23:0]           ws1, hs1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= issue;
      s1_emit_q  <= issue && present0;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q  <= item_i;
    s1_step_q  <= has_step0;
    s1_match_q <= look_match;
  end

  assign g1 = glyph_t'(glyph_rdata);

  // kerning amount of the single agreeing value
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      for (int i = 0; i < KERN_DEPTH; i++) begin
        amt_col[b][i] = amt_q[i][b];
      end
      kern1[b] = |(s1_match_q & amt_col[b]);
    end
  end

  assign scale_s = $signed({1'b0, scale_q});
  assign adv_sum = $signed({2'b00, adv_q}) + $signed({{2{kern1[7]}}, kern1});
  assign step1   = adv_sum * scale_s;
  assign oxs1    = $signed(g1.offset_x) * scale_s;
  assign oys1    = $signed(g1.offset_y) * scale_s;
  assign ws1     = g1.glyph_width * scale_q;
  assign hs1     = g1.glyph_height * scale_q;

  // advance of the last character, kept current across glyph reloads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adv_q <= '0;
      lc1_q <= '0;
    end else if (s1_valid_q) begin
      if (s1_item_q.kind == KIND_CHAR) begin
        adv_q <= g1.advance;
        lc1_q <= s1_item_q.code;
      end else if (s1_item_q.kind == KIND_GLYPH && s1_item_q.code == lc1_q) begin
        adv_q <= s1_item_q.advance;
      end
    end
  end

  // ---------------- stage 2: pen ----------------
  logic                s2_char_q;
  logic                s2_step_q;
  logic                s2_sos_q;
  logic signed [26:0]  s2_stepv_q;
  logic signed [24:0]  s2_oxs_q, s2_oys_q;
  logic [23:0]         s2_ws_q, s2_hs_q;
  logic [11:0]         s2_tl_q, s2_tt_q;
  logic [12:0]         s2_tr_q, s2_tb_q;
  logic [7:0]          s2_code_q;
  logic signed [23:0]  pen_q;
  logic signed [23:0]  pen_base, pen_d;
  logic signed [27:0]  pen_sum;
  logic signed [25:0]  ymax2, xoff2;
  logic signed [26:0]  ymin2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_char_q <= 1'b0;
      s2_emit_q <= 1'b0;
    end else begin
      s2_char_q <= s1_valid_q && (s1_item_q.kind == KIND_CHAR);
      s2_emit_q <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_step_q  <= s1_step_q;
    s2_sos_q   <= s1_item_q.start_of_string;
    s2_stepv_q <= step1;
    s2_oxs_q   <= oxs1;
    s2_oys_q   <= oys1;
    s2_ws_q    <= ws1;
    s2_hs_q    <= hs1;
    s2_tl_q    <= g1.atlas_x;
    s2_tt_q    <= g1.atlas_y;
    s2_tr_q    <= {1'b0, g1.atlas_x} + {5'b0, g1.glyph_width};
    s2_tb_q    <= {1'b0, g1.atlas_y} + {5'b0, g1.glyph_height};
    s2_code_q  <= s1_item_q.code;
  end

  // pen step with saturation
  assign pen_base = s2_sos_q ? '0 : pen_q;
  assign pen_sum  = $signed({{4{pen_base[23]}}, pen_base}) + $signed({s2_stepv_q[26], s2_stepv_q});
  assign pen_d    = s2_step_q ? $signed(sat24(pen_sum)) : pen_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q <= '0;
    end else if (s2_char_q) begin
      pen_q <= pen_d;
    end
  end

  // vertical edges and right edge offset, off the pen loop
  assign ymax2 = -$signed({s2_oys_q[24], s2_oys_q});
  assign ymin2 = $signed({ymax2[25], ymax2}) - $signed({3'b000, s2_hs_q});
  assign xoff2 = $signed({s2_oxs_q[24], s2_oxs_q}) + $signed({2'b00, s2_ws_q});

  // ---------------- stage 3: quad ----------------
  logic signed [23:0] s3_pen_q;
  logic signed [24:0] s3_oxs_q;
  logic signed [25:0] s3_xoff_q;
  logic [23:0]        s3_ymin_q, s3_ymax_q;
  logic [11:0]        s3_tl_q, s3_tt_q;
  logic [12:0]        s3_tr_q, s3_tb_q;
  logic [7:0]         s3_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_emit_q <= 1'b0;
    end else begin
      s3_emit_q <= s2_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_pen_q  <= pen_d;
    s3_oxs_q  <= s2_oxs_q;
    s3_xoff_q <= xoff2;
    s3_ymin_q <= sat24({ymin2[26], ymin2});
    s3_ymax_q <= sat24({{2{ymax2[25]}}, ymax2});
    s3_tl_q   <= s2_tl_q;
    s3_tt_q   <= s2_tt_q;
    s3_tr_q   <= s2_tr_q;
    s3_tb_q   <= s2_tb_q;
    s3_code_q <= s2_code_q;
  end

  assign res_push_o = s3_emit_q;

  always_comb begin
    res_o.quad_x_min = sat24($signed({{4{s3_pen_q[23]}}, s3_pen_q})
                           + $signed({{3{s3_oxs_q[24]}}, s3_oxs_q}));
    res_o.quad_x_max = sat24($signed({{4{s3_pen_q[23]}}, s3_pen_q})
                           + $signed({{2{s3_xoff_q[25]}}, s3_xoff_q}));
    res_o.quad_y_min = s3_ymin_q;
    res_o.quad_y_max = s3_ymax_q;
    res_o.tex_left   = s3_tl_q;
    res_o.tex_top    = s3_tt_q;
    res_o.tex_right  = s3_tr_q;
    res_o.tex_bottom = s3_tb_q;
    res_o.glyph_char = s3_code_q;
  end

  // credit check keeps the result queue from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (res_count_i < RCW'(OUT_DEPTH)))
    else $error("result transfer into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    glyph_wr |=> present_q[$past(gaddr)])
    else $error("glyph load did not mark entry present");

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= KFW'(KERN_DEPTH))
    else $error("kerning fill beyond table depth");

endmodule

### test/quad_checker.sv
module quad_checker
  import gtl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         op_i,
  input  logic [7:0]         code_i,
  input  logic [7:0]         second_code_i,
  input  logic [11:0]        atlas_x_i,
  input  logic [11:0]        atlas_y_i,
  input  logic [7:0]         glyph_width_i,
  input  logic [7:0]         glyph_height_i,
  input  logic signed [7:0]  offset_x_i,
  input  logic signed [7:0]  offset_y_i,
  input  logic [7:0]         advance_i,
  input  logic signed [7:0]  kern_amount_i,
  input  logic               start_of_string_i,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [23:0] quad_x_min_o,
  input  logic signed [23:0] quad_x_max_o,
  input  logic signed [23:0] quad_y_min_o,
  input  logic signed [23:0] quad_y_max_o,
  input  logic [11:0]        tex_left_o,
  input  logic [11:0]        tex_top_o,
  input  logic [12:0]        tex_right_o,
  input  logic [12:0]        tex_bottom_o,
  input  logic [7:0]         glyph_char_o,
  output int                 quad_pending_o,
  output int                 mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     GLYPHS  = 256;
  localparam int     KERNS   = 64;
  localparam longint POS_MAX = 64'sd8388607;
  localparam longint POS_MIN = -64'sd8388608;

  // glyph table and kerning pairs as the block should hold them
  logic              glyph_present [GLYPHS];
  glyph_t            glyph_tab     [GLYPHS];
  logic [7:0]        kern_first    [KERNS];
  logic [7:0]        kern_second   [KERNS];
  logic signed [7:0] kern_amt      [KERNS];
  int                kern_count;

  // pen state along the current string
  longint            pen;
  logic [7:0]        prev_code;
  logic              prev_present;
  logic [15:0]       scale;

  result_t           quad_q [$];
  int                mismatches;

  function automatic longint clamp24(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict
    result_t quad;
    glyph_t  g;
    longint  sc, kern_v, x_min, x_max, y_max;
    if (!rst_ni) begin
      for (int i = 0; i < GLYPHS; i++) glyph_present[i] = 1'b0;
      kern_count   = 0;
      pen          = 0;
      prev_code    = '0;
      prev_present = 1'b0;
      scale        = SCALE_RESET;
      quad_q.delete();
      mismatches   = 0;
    end else begin
      // scale register write
      if (cfg_we_i) scale = cfg_wdata_i;

      // item transfer
      if (push && !full) begin
        sc = longint'(scale);
        case (op_i)
          OP_GLYPH: begin
            glyph_present[code_i] = 1'b1;
            glyph_tab[code_i] = '{atlas_x: atlas_x_i, atlas_y: atlas_y_i,
                                  glyph_width: glyph_width_i,
                                  glyph_height: glyph_height_i,
                                  offset_x: offset_x_i, offset_y: offset_y_i,
                                  advance: advance_i};
          end
          OP_KERN: begin
            // loads past the table depth are dropped
            if (kern_count < KERNS) begin
              kern_first[kern_count]  = code_i;
              kern_second[kern_count] = second_code_i;
              kern_amt[kern_count]    = kern_amount_i;
              kern_count++;
            end
          end
          OP_CHAR: begin
            if (start_of_string_i) begin
              pen          = 0;
              prev_code    = '0;
              prev_present = 1'b0;
            end
            // advance past the previous glyph, newest matching pair wins
            if (prev_present) begin
              kern_v = 0;
              for (int i = 0; i < kern_count; i++)
                if (kern_first[i] == prev_code && kern_second[i] == code_i)
                  kern_v = kern_amt[i];
              pen = clamp24(pen + (longint'(glyph_tab[prev_code].advance) + kern_v) * sc);
            end
            prev_code    = code_i;
            prev_present = glyph_present[code_i];
            // present glyph gives one quad
            if (prev_present) begin
              g     = glyph_tab[code_i];
              x_min = pen + longint'($signed(g.offset_x)) * sc;
              x_max = x_min + longint'(g.glyph_width) * sc;
              y_max = -longint'($signed(g.offset_y)) * sc;
              quad.quad_x_min = 24'(clamp24(x_min));
              quad.quad_x_max = 24'(clamp24(x_max));
              quad.quad_y_min = 24'(clamp24(y_max - longint'(g.glyph_height) * sc));
              quad.quad_y_max = 24'(clamp24(y_max));
              quad.tex_left   = g.atlas_x;
              quad.tex_top    = g.atlas_y;
              quad.tex_right  = 13'(g.atlas_x) + 13'(g.glyph_width);
              quad.tex_bottom = 13'(g.atlas_y) + 13'(g.glyph_height);
              quad.glyph_char = code_i;
              quad_q.push_back(quad);
            end
          end
          default: ; // unused op leaves everything as it is
        endcase
      end

      // result transfer against the oldest expected quad
      if (pop && !empty) begin
        if (quad_q.size() == 0) begin
          $error("quad transfer with no quad expected");
          mismatches++;
        end else begin
          quad = quad_q.pop_front();
          check_field("quad_x_min", $signed(quad.quad_x_min), quad_x_min_o);
          check_field("quad_x_max", $signed(quad.quad_x_max), quad_x_max_o);
          check_field("quad_y_min", $signed(quad.quad_y_min), quad_y_min_o);
          check_field("quad_y_max", $signed(quad.quad_y_max), quad_y_max_o);
          check_field("tex_left", quad.tex_left, tex_left_o);
          check_field("tex_top", quad.tex_top, tex_top_o);
          check_field("tex_right", quad.tex_right, tex_right_o);
          check_field("tex_bottom", quad.tex_bottom, tex_bottom_o);
          check_field("glyph_char", quad.glyph_char, glyph_char_o);
        end
      end
    end
    quad_pending_o   <= quad_q.size();
    mismatch_count_o <= mismatches;
  end

endmodule

### test/tb.sv
module tb;
  import gtl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam int         ITEMS_PER_PHASE = 100;
  localparam int         PHASES          = 6;
  localparam int         HOLD_CYCLES     = 300;
  localparam int         SETTLE_CYCLES   = 16;
  localparam int         WATCHDOG_LIMIT  = 4000;
  localparam logic [7:0] CLUSTER_BASE    = 8'd60;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        code;
    logic [7:0]        second_code;
    logic [11:0]       atlas_x;
    logic [11:0]       atlas_y;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic [7:0]        advance;
    logic signed [7:0] kern_amount;
    logic              start_of_string;
  } text_item_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               cfg_we_i          = 1'b0;
  logic [15:0]        cfg_wdata_i       = SCALE_RESET;
  logic               push              = 1'b0;
  logic               full;
  logic [1:0]         op_i              = OP_GLYPH;
  logic [7:0]         code_i            = '0;
  logic [7:0]         second_code_i     = '0;
  logic [11:0]        atlas_x_i         = '0;
  logic [11:0]        atlas_y_i         = '0;
  logic [7:0]         glyph_width_i     = '0;
  logic [7:0]         glyph_height_i    = '0;
  logic signed [7:0]  offset_x_i        = '0;
  logic signed [7:0]  offset_y_i        = '0;
  logic [7:0]         advance_i         = '0;
  logic signed [7:0]  kern_amount_i     = '0;
  logic               start_of_string_i = 1'b0;
  logic               empty;
  logic               pop               = 1'b0;
  logic signed [23:0] quad_x_min_o;
  logic signed [23:0] quad_x_max_o;
  logic signed [23:0] quad_y_min_o;
  logic signed [23:0] quad_y_max_o;
  logic [11:0]        tex_left_o;
  logic [11:0]        tex_top_o;
  logic [12:0]        tex_right_o;
  logic [12:0]        tex_bottom_o;
  logic [7:0]         glyph_char_o;

  int quad_pending;
  int mismatch_count;
  int send_idle   = 0;
  int recv_stall  = 0;
  bit hold_pop    = 1'b0;
  int stuck_cycles = 0;
  int send_plan [PHASES] = '{0, 71, 0, 20, 0, 20};
  int recv_plan [PHASES] = '{0, 0, 71, 20, 0, 20};

  glyph_text_layout i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .push              (push),
    .full              (full),
    .op_i              (op_i),
    .code_i            (code_i),
    .second_code_i     (second_code_i),
    .atlas_x_i         (atlas_x_i),
    .atlas_y_i         (atlas_y_i),
    .glyph_width_i     (glyph_width_i),
    .glyph_height_i    (glyph_height_i),
    .offset_x_i        (offset_x_i),
    .offset_y_i        (offset_y_i),
    .advance_i         (advance_i),
    .kern_amount_i     (kern_amount_i),
    .start_of_string_i (start_of_string_i),
    .empty             (empty),
    .pop               (pop),
    .quad_x_min_o      (quad_x_min_o),
    .quad_x_max_o      (quad_x_max_o),
    .quad_y_min_o      (quad_y_min_o),
    .quad_y_max_o      (quad_y_max_o),
    .tex_left_o        (tex_left_o),
    .tex_top_o         (tex_top_o),
    .tex_right_o       (tex_right_o),
    .tex_bottom_o      (tex_bottom_o),
    .glyph_char_o      (glyph_char_o)
  );

  quad_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .push              (push),
    .full              (full),
    .op_i              (op_i),
    .code_i            (code_i),
    .second_code_i     (second_code_i),
    .atlas_x_i         (atlas_x_i),
    .atlas_y_i         (atlas_y_i),
    .glyph_width_i     (glyph_width_i),
    .glyph_height_i    (glyph_height_i),
    .offset_x_i        (offset_x_i),
    .offset_y_i        (offset_y_i),
    .advance_i         (advance_i),
    .kern_amount_i     (kern_amount_i),
    .start_of_string_i (start_of_string_i),
    .empty             (empty),
    .pop               (pop),
    .quad_x_min_o      (quad_x_min_o),
    .quad_x_max_o      (quad_x_max_o),
    .quad_y_min_o      (quad_y_min_o),
    .quad_y_max_o      (quad_y_max_o),
    .tex_left_o        (tex_left_o),
    .tex_top_o         (tex_top_o),
    .tex_right_o       (tex_right_o),
    .tex_bottom_o      (tex_bottom_o),
    .glyph_char_o      (glyph_char_o),
    .quad_pending_o    (quad_pending),
    .mismatch_count_o  (mismatch_count)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_pop) begin
        hold_pop = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        pop <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // fully random fields, op set to the unused code
  function automatic text_item_t noise_item();
    text_item_t   s;
    logic [95:0]  raw;
    raw  = {$urandom, $urandom, $urandom};
    s    = raw[$bits(text_item_t)-1:0];
    s.op = OP_UNUSED;
    return s;
  endfunction

  // mostly codes from a small set so strings hit loaded glyphs and pairs
  function automatic logic [7:0] pick_code();
    if ($urandom_range(99) < 75) return 8'(CLUSTER_BASE + $urandom_range(15));
    return 8'($urandom);
  endfunction

  // one input transfer, then an optional sender gap
  task automatic send(input text_item_t s);
    op_i              <= s.op;
    code_i            <= s.code;
    second_code_i     <= s.second_code;
    atlas_x_i         <= s.atlas_x;
    atlas_y_i         <= s.atlas_y;
    glyph_width_i     <= s.glyph_width;
    glyph_height_i    <= s.glyph_height;
    offset_x_i        <= s.offset_x;
    offset_y_i        <= s.offset_y;
    advance_i         <= s.advance;
    kern_amount_i     <= s.kern_amount;
    start_of_string_i <= s.start_of_string;
    push              <= 1'b1;
    do @(posedge clk_i); while (full);
    if ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic send_glyph(input logic [7:0] code, input logic [11:0] ax, ay,
                            input logic [7:0] w, h, input logic signed [7:0] ox, oy,
                            input logic [7:0] adv);
    text_item_t s;
    s = noise_item();
    s.op           = OP_GLYPH;
    s.code         = code;
    s.atlas_x      = ax;
    s.atlas_y      = ay;
    s.glyph_width  = w;
    s.glyph_height = h;
    s.offset_x     = ox;
    s.offset_y     = oy;
    s.advance      = adv;
    send(s);
  endtask

  task automatic send_kern(input logic [7:0] first, second, input logic signed [7:0] amt);
    text_item_t s;
    s = noise_item();
    s.op          = OP_KERN;
    s.code        = first;
    s.second_code = second;
    s.kern_amount = amt;
    send(s);
  endtask

  task automatic send_char(input logic [7:0] code, input logic sos);
    text_item_t s;
    s = noise_item();
    s.op              = OP_CHAR;
    s.code            = code;
    s.start_of_string = sos;
    send(s);
  endtask

  // stop offering, wait for every quad, then let loads drain
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (quad_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [15:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // stimulus
  initial begin
    text_item_t s;
    int         roll;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: character before any load, extremes, pairs, reloads
    send_char(8'd65, 1'b1);
    send_glyph(8'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'sh80, 8'sh80, 8'd0);
    send_glyph(8'd255, 12'hfff, 12'hfff, 8'hff, 8'hff, 8'sh7f, 8'sh7f, 8'hff);
    send_glyph(8'd65, 12'd100, 12'd200, 8'd10, 8'd12, 8'sd1, -8'sd9, 8'd11);
    send_kern(8'd65, 8'd255, 8'sh80);
    send_kern(8'd255, 8'd65, 8'sh7f);
    send_kern(8'd65, 8'd65, 8'sd5);
    send_kern(8'd65, 8'd65, -8'sd3);
    send(noise_item());
    send_char(8'd65, 1'b1);
    send_char(8'd255, 1'b0);
    send_char(8'd65, 1'b0);
    send_char(8'd65, 1'b0);
    // missing glyph mid string, then no advance for the next one
    send_char(8'd77, 1'b0);
    send_char(8'd0, 1'b0);
    send_char(8'd0, 1'b0);
    // reload of the previous glyph before the next character
    send_glyph(8'd0, 12'd7, 12'd9, 8'd3, 8'd4, 8'sd0, 8'sd0, 8'hff);
    send_char(8'd255, 1'b0);
    send_char(8'd65, 1'b1);
    send_char(8'd255, 1'b1);
    send_char(8'd0, 1'b0);

    // random phases, each with its own scale and idling
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0:       write_scale(SCALE_RESET);
        1:       write_scale(16'hffff);
        2:       write_scale(16'h0000);
        3:       write_scale(16'($urandom));
        4:       write_scale(16'h0001);
        default: write_scale(16'h0180);
      endcase
      send_idle  = send_plan[phase];
      recv_stall = recv_plan[phase];
      if (phase == 0) hold_pop = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          send_char(pick_code(), $urandom_range(99) < 15);
        end else if (roll < 75) begin
          s = noise_item();
          s.op   = OP_GLYPH;
          s.code = pick_code();
          send(s);
        end else if (roll < 87) begin
          s = noise_item();
          s.op          = OP_KERN;
          s.code        = pick_code();
          s.second_code = pick_code();
          send(s);
        end else begin
          send(noise_item());
        end
      end
    end

    settle();
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### files.f
rtl/gtl_pkg.sv
rtl/gtl_ram.sv
rtl/gtl_queue.sv
rtl/gtl_front.sv
rtl/gtl_back.sv
rtl/glyph_text_layout.sv
test/quad_checker.sv
test/tb.sv
